### sv/matrix_chain_order_solver_top_macros.svh
// Assertion macros for the matrix chain order solver.
// Included by the top level; no other dependencies.
`ifndef MATRIX_CHAIN_ORDER_SOLVER_TOP_MACROS_SVH
`define MATRIX_CHAIN_ORDER_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, gated by the active-low reset
`define MCOS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcos check failed");

// Next-cycle implication, gated by the active-low reset
`define MCOS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcos check failed");

`endif

### sv/mcos_pkg.sv
// Shared types and constants of the matrix chain order solver.
// No dependencies.
package mcos_pkg;

    localparam int DIM_W   = 16;
    localparam int IDX_W   = 5;
    localparam int COST_W  = 52;
    localparam int SPLIT_W = 4;
    localparam int STAT_W  = 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd2;

    // Sequencer states
    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_INIT    = 12'b0000_0000_0010,
        ST_ROW_A   = 12'b0000_0000_0100,
        ST_ROW_B   = 12'b0000_0000_1000,
        ST_ROW_C   = 12'b0000_0001_0000,
        ST_K_RD    = 12'b0000_0010_0000,
        ST_K_MUL1  = 12'b0000_0100_0000,
        ST_K_MUL2  = 12'b0000_1000_0000,
        ST_K_CMP   = 12'b0001_0000_0000,
        ST_ROW_WR  = 12'b0010_0000_0000,
        ST_RES_RD  = 12'b0100_0000_0000,
        ST_RES_OUT = 12'b1000_0000_0000
    } mcos_state_t;

endpackage

### sv/matrix_chain_order_solver_top.sv
// Matrix chain order solver: dimension load, table fill sequencer, queries.
// Depends on mcos_pkg and matrix_chain_order_solver_top_macros.svh.
//
// Usage:
//   Input requests (s_valid/s_ready) either load one chain dimension (op 0)
//   or query a subchain (op 1). The load with last set ends the chain and
//   starts the fill of the cost/split table; its result is the cost of the
//   whole chain. Results leave on m_valid/m_ready with cost, split, status.
//   A load without last gives no result. A bad query or a last load with
//   under two dimensions answers the next cycle. A good query reads its
//   table entry in ST_RES_RD and registers the result in ST_RES_OUT.
//   Fill: one multiply/add/compare datapath, reused for every candidate,
//   evaluates the split candidates one at a time in ST_K_RD, ST_K_MUL1,
//   ST_K_MUL2 and ST_K_CMP; each subchain row adds setup in ST_ROW_A,
//   ST_ROW_B, ST_ROW_C and write-back in ST_ROW_WR, and ST_INIT writes the
//   diagonal one entry at a time. The result is then read in ST_RES_RD and
//   ST_RES_OUT. The single table write port and dimension read port serialise these steps.
//   s_ready is high only while the sequencer is idle and the output register
//   is free or being emptied; a stalled receiver holds the result and blocks
//   new requests. Reset clears control state; memories are not cleared and
//   are only read where written.
`include "matrix_chain_order_solver_top_macros.svh"

module matrix_chain_order_solver_top
    import mcos_pkg::*;
#(
    parameter int MAX_MATRICES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [DIM_W-1:0]   s_dim,
    input  logic               s_last,
    input  logic [IDX_W-1:0]   s_first_index,
    input  logic [IDX_W-1:0]   s_last_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COST_W-1:0]  m_cost,
    output logic [SPLIT_W-1:0] m_split,
    output logic [STAT_W-1:0]  m_status
);

    localparam int DIM_DEPTH = MAX_MATRICES + 1;
    localparam int TAB_DEPTH = (MAX_MATRICES * (MAX_MATRICES + 1)) / 2;
    localparam int IW        = $clog2(MAX_MATRICES + 1);
    localparam int DLW       = $clog2(MAX_MATRICES + 2);
    localparam int TAW       = $clog2(TAB_DEPTH);
    localparam int TW        = 2 * IW;
    localparam int CW        = (DLW > IDX_W) ? DLW : IDX_W;
    localparam int P1W       = 2 * DIM_W;
    localparam int PW        = 3 * DIM_W;

    // Table slot of subchain a..b
    function automatic logic [TAW-1:0] slot(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [TW-1:0] t;
        begin
            t = TW'(b) * (TW'(b) - TW'(1));
            slot = TAW'((t >> 1) + TW'(a) - TW'(1));
        end
    endfunction

    // Control registers
    mcos_state_t         state_reg, state_next;
    logic [DLW-1:0]      dims_loaded_reg, dims_loaded_next;
    logic                table_ready_reg, table_ready_next;
    logic                ovf_reg, ovf_next;
    logic                m_valid_reg, m_valid_next;

    // Sequencer indices and datapath registers
    logic [IW-1:0]       m_reg, m_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       j_reg, j_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [IW-1:0]       bestk_reg, bestk_next;
    logic [DIM_W-1:0]    di_reg, di_next;
    logic [DIM_W-1:0]    dj_reg, dj_next;
    logic [P1W-1:0]      prod1_reg, prod1_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [COST_W-1:0]   sum_reg, sum_next;
    logic [COST_W-1:0]   best_reg, best_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [COST_W-1:0]   m_cost_reg, m_cost_next;
    logic [SPLIT_W-1:0]  m_split_reg, m_split_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;

    // Memories
    logic [DIM_W-1:0]    dim_mem [DIM_DEPTH];
    logic [COST_W-1:0]   cost_mem [TAB_DEPTH];
    logic [SPLIT_W-1:0]  split_mem [TAB_DEPTH];

    logic                dim_we;
    logic [IW-1:0]       dim_waddr;
    logic [IW-1:0]       dim_raddr;
    logic [DIM_W-1:0]    dim_rd_reg;

    logic                tab_we;
    logic [TAW-1:0]      tab_waddr;
    logic [COST_W-1:0]   tab_wcost;
    logic [SPLIT_W-1:0]  tab_wsplit;
    logic [TAW-1:0]      raddr_a;
    logic [TAW-1:0]      raddr_b;
    logic [COST_W-1:0]   cost_a_reg;
    logic [COST_W-1:0]   cost_b_reg;
    logic [SPLIT_W-1:0]  split_a_reg;

    // Handshake and request decode
    logic                out_free;
    logic                accept;
    logic [DLW-1:0]      dl_base;
    logic                ov_base;
    logic                room;
    logic [DLW-1:0]      dl_after;
    logic                ov_after;
    logic [CW-1:0]       fi_ext;
    logic [CW-1:0]       li_ext;
    logic [CW-1:0]       mcount;
    logic                q_bad;

    // Shared add/compare unit
    logic [COST_W:0]     ab_sum;
    logic [COST_W:0]     q_sum;
    logic [COST_W-1:0]   q_val;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign m_valid  = m_valid_reg;
    assign m_cost   = m_cost_reg;
    assign m_split  = m_split_reg;
    assign m_status = m_status_reg;

    // Load bookkeeping: a finished table restarts the chain
    assign dl_base  = table_ready_reg ? '0 : dims_loaded_reg;
    assign ov_base  = table_ready_reg ? 1'b0 : ovf_reg;
    assign room     = dl_base < DLW'(DIM_DEPTH);
    assign dl_after = room ? dl_base + DLW'(1) : dl_base;
    assign ov_after = room ? ov_base : 1'b1;

    // Query index check
    assign fi_ext = CW'(s_first_index);
    assign li_ext = CW'(s_last_index);
    assign mcount = CW'(dims_loaded_reg) - CW'(1);
    assign q_bad  = !table_ready_reg || (fi_ext == '0) || (li_ext > mcount)
                    || (fi_ext > li_ext);

    // Saturating sums
    assign ab_sum = {1'b0, cost_a_reg} + {1'b0, cost_b_reg};
    assign q_sum  = {1'b0, sum_reg} + (COST_W + 1)'(prod_reg);
    assign q_val  = q_sum[COST_W] ? COST_MAX : q_sum[COST_W-1:0];

    // Memory addressing
    assign dim_we    = accept && (s_op == OP_LOAD) && room;
    assign dim_waddr = IW'(dl_base);
    assign raddr_a   = (state_reg == ST_K_RD) ? slot(i_reg, k_reg) : slot(i_reg, j_reg);
    assign raddr_b   = slot(k_reg + IW'(1), j_reg);

    always_comb begin
        case (state_reg)
            ST_ROW_A: dim_raddr = i_reg - IW'(1);
            ST_ROW_B: dim_raddr = j_reg;
            default:  dim_raddr = k_reg;
        endcase
    end

    assign tab_we     = (state_reg == ST_INIT) || (state_reg == ST_ROW_WR);
    assign tab_waddr  = (state_reg == ST_INIT) ? slot(i_reg, i_reg) : slot(i_reg, j_reg);
    assign tab_wcost  = (state_reg == ST_INIT) ? '0 : best_reg;
    assign tab_wsplit = (state_reg == ST_INIT) ? '0 : SPLIT_W'(bestk_reg);

    // Dimension memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (dim_we) begin
            dim_mem[dim_waddr] <= s_dim;
        end
        dim_rd_reg <= dim_mem[dim_raddr];
    end

    // Cost/split table: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (tab_we) begin
            cost_mem[tab_waddr]  <= tab_wcost;
            split_mem[tab_waddr] <= tab_wsplit;
        end
        cost_a_reg  <= cost_mem[raddr_a];
        cost_b_reg  <= cost_mem[raddr_b];
        split_a_reg <= split_mem[raddr_a];
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next       = state_reg;
        dims_loaded_next = dims_loaded_reg;
        table_ready_next = table_ready_reg;
        ovf_next         = ovf_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_next           = m_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        bestk_next       = bestk_reg;
        di_next          = di_reg;
        dj_next          = dj_reg;
        prod1_next       = prod1_reg;
        prod_next        = prod_reg;
        sum_next         = sum_reg;
        best_next        = best_reg;
        res_status_next  = res_status_reg;
        m_cost_next      = m_cost_reg;
        m_split_next     = m_split_reg;
        m_status_next    = m_status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_LOAD)) begin
                    table_ready_next = 1'b0;
                    dims_loaded_next = dl_after;
                    ovf_next         = ov_after;
                    if (s_last) begin
                        if (dl_after < DLW'(2)) begin
                            // no matrix in the chain
                            dims_loaded_next = '0;
                            ovf_next         = 1'b0;
                            m_valid_next     = 1'b1;
                            m_cost_next      = '0;
                            m_split_next     = '0;
                            m_status_next    = STAT_BAD;
                        end else begin
                            m_next          = IW'(dl_after - DLW'(1));
                            i_next          = IW'(1);
                            res_status_next = ov_after ? STAT_OVF : STAT_OK;
                            state_next      = ST_INIT;
                        end
                    end
                end else if (accept) begin
                    if (q_bad) begin
                        m_valid_next  = 1'b1;
                        m_cost_next   = '0;
                        m_split_next  = '0;
                        m_status_next = STAT_BAD;
                    end else begin
                        i_next          = IW'(s_first_index);
                        j_next          = IW'(s_last_index);
                        res_status_next = STAT_OK;
                        state_next      = ST_RES_RD;
                    end
                end
            end

            // Diagonal entries: zero cost, zero split
            ST_INIT: begin
                if (i_reg == m_reg) begin
                    i_next = IW'(1);
                    if (m_reg == IW'(1)) begin
                        j_next     = m_reg;
                        state_next = ST_RES_RD;
                    end else begin
                        j_next     = IW'(2);
                        state_next = ST_ROW_A;
                    end
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end

            ST_ROW_A: begin
                state_next = ST_ROW_B;
            end

            ST_ROW_B: begin
                di_next    = dim_rd_reg;
                state_next = ST_ROW_C;
            end

            ST_ROW_C: begin
                dj_next    = dim_rd_reg;
                k_next     = i_reg;
                state_next = ST_K_RD;
            end

            ST_K_RD: begin
                state_next = ST_K_MUL1;
            end

            // First product and the sum of the two sub-costs
            ST_K_MUL1: begin
                prod1_next = P1W'(di_reg) * P1W'(dim_rd_reg);
                sum_next   = ab_sum[COST_W] ? COST_MAX : ab_sum[COST_W-1:0];
                state_next = ST_K_MUL2;
            end

            ST_K_MUL2: begin
                prod_next  = PW'(prod1_reg) * PW'(dj_reg);
                state_next = ST_K_CMP;
            end

            // Candidate compare; the first candidate always wins
            ST_K_CMP: begin
                if ((k_reg == i_reg) || (q_val < best_reg)) begin
                    best_next  = q_val;
                    bestk_next = k_reg;
                end
                if (k_reg == j_reg - IW'(1)) begin
                    state_next = ST_ROW_WR;
                end else begin
                    k_next     = k_reg + IW'(1);
                    state_next = ST_K_RD;
                end
            end

            // Write the row result, then step to the next subchain or to the result read
            ST_ROW_WR: begin
                if (j_reg < m_reg) begin
                    i_next     = i_reg + IW'(1);
                    j_next     = j_reg + IW'(1);
                    state_next = ST_ROW_A;
                end else if (i_reg == IW'(1)) begin
                    state_next = ST_RES_RD;
                end else begin
                    j_next     = j_reg - i_reg + IW'(2);
                    i_next     = IW'(1);
                    state_next = ST_ROW_A;
                end
            end

            ST_RES_RD: begin
                state_next = ST_RES_OUT;
            end

            ST_RES_OUT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_cost_next      = cost_a_reg;
                    m_split_next     = split_a_reg;
                    m_status_next    = res_status_reg;
                    table_ready_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            dims_loaded_reg <= '0;
            table_ready_reg <= 1'b0;
            ovf_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            dims_loaded_reg <= dims_loaded_next;
            table_ready_reg <= table_ready_next;
            ovf_reg         <= ovf_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload and datapath
    always_ff @(posedge aclk) begin
        m_reg          <= m_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        bestk_reg      <= bestk_next;
        di_reg         <= di_next;
        dj_reg         <= dj_next;
        prod1_reg      <= prod1_next;
        prod_reg       <= prod_next;
        sum_reg        <= sum_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        m_cost_reg     <= m_cost_next;
        m_split_reg    <= m_split_next;
        m_status_reg   <= m_status_next;
    end

    // Checks
    `MCOS_ASSERT_IMP(a_bad_zero, aclk, aresetn, m_valid_reg && (m_status_reg == STAT_BAD), (m_cost_reg == '0) && (m_split_reg == '0))
    `MCOS_ASSERT_IMP(a_k_range, aclk, aresetn, state_reg == ST_K_CMP, (k_reg >= i_reg) && (k_reg < j_reg))
    `MCOS_ASSERT_IMP(a_ready_dims, aclk, aresetn, table_ready_reg, dims_loaded_reg >= DLW'(2))
    `MCOS_ASSERT_NXT(a_res_out, aclk, aresetn, (state_reg == ST_RES_OUT) && out_free, m_valid_reg && table_ready_reg)

endmodule

### tb/tb_top.sv
// Self-checking testbench for matrix_chain_order_solver_top: loads and queries
// matrix chains, predicts every answer in-line and compares field by field.
// Depends on mcos_pkg and the solver RTL only.
module tb_top
    import mcos_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_M           = 16;
    localparam int DIM_SLOTS       = MAX_M + 1;
    localparam int TAB_SLOTS       = (MAX_M * (MAX_M + 1)) / 2;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [SPLIT_W-1:0] split;
        logic [STAT_W-1:0]  status;
    } answer_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [DIM_W-1:0]   s_dim;
    logic               s_last;
    logic [IDX_W-1:0]   s_first_index;
    logic [IDX_W-1:0]   s_last_index;
    logic               m_valid;
    logic               m_ready;
    logic [COST_W-1:0]  m_cost;
    logic [SPLIT_W-1:0] m_split;
    logic [STAT_W-1:0]  m_status;

    // Shadow copy of the solver state
    logic [DIM_W-1:0]   chain_dims [DIM_SLOTS];
    logic [COST_W-1:0]  cost_tab   [TAB_SLOTS];
    logic [SPLIT_W-1:0] split_tab  [TAB_SLOTS];
    int                 dims_count;
    bit                 chain_solved;
    bit                 dim_dropped;

    answer_t pending_answers [$];
    int      fail_count;
    int      items_sent;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off_req;

    matrix_chain_order_solver_top #(
        .MAX_MATRICES(MAX_M)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_dim         (s_dim),
        .s_last        (s_last),
        .s_first_index (s_first_index),
        .s_last_index  (s_last_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cost        (m_cost),
        .m_split       (m_split),
        .m_status      (m_status)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Chain solver prediction
    // ------------------------------------------------------------------
    function automatic int tri_slot(int i, int j);
        return (i - 1) + (j * (j - 1)) / 2;
    endfunction

    function automatic logic [COST_W-1:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'(COST_MAX)) ? COST_MAX : s[COST_W-1:0];
    endfunction

    // Triangular DP over subchain length; first candidate always taken
    task automatic fill_cost_table(int m);
        logic [63:0]        prod;
        logic [COST_W-1:0]  q;
        logic [COST_W-1:0]  best;
        logic [SPLIT_W-1:0] best_k;
        bit                 have;
        for (int i = 1; i <= m; i++) begin
            cost_tab[tri_slot(i, i)]  = '0;
            split_tab[tri_slot(i, i)] = '0;
        end
        for (int len = 2; len <= m; len++) begin
            for (int i = 1; i + len - 1 <= m; i++) begin
                int j;
                j = i + len - 1;
                have = 1'b0;
                best = '0;
                best_k = '0;
                for (int k = i; k < j; k++) begin
                    prod = 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
                    q = sat_sum(64'(sat_sum(64'(cost_tab[tri_slot(i, k)]),
                                            64'(cost_tab[tri_slot(k + 1, j)]))), prod);
                    if (!have || q < best) begin
                        have   = 1'b1;
                        best   = q;
                        best_k = k[SPLIT_W-1:0];
                    end
                end
                cost_tab[tri_slot(i, j)]  = best;
                split_tab[tri_slot(i, j)] = best_k;
            end
        end
    endtask

    task automatic predict_chain_answer(logic op, logic [DIM_W-1:0] dim, logic last,
                                        logic [IDX_W-1:0] fi, logic [IDX_W-1:0] li);
        answer_t ans;
        int      m;
        if (op == OP_LOAD) begin
            // a finished chain is dropped by the next load
            if (chain_solved) begin
                dims_count   = 0;
                chain_solved = 1'b0;
                dim_dropped  = 1'b0;
            end
            if (dims_count < DIM_SLOTS) begin
                chain_dims[dims_count] = dim;
                dims_count++;
            end else begin
                dim_dropped = 1'b1;
            end
            if (last) begin
                if (dims_count < 2) begin
                    // no matrix at all
                    dims_count  = 0;
                    dim_dropped = 1'b0;
                    ans = '{cost: '0, split: '0, status: STAT_BAD};
                end else begin
                    m = dims_count - 1;
                    fill_cost_table(m);
                    chain_solved = 1'b1;
                    ans = '{cost: cost_tab[tri_slot(1, m)], split: split_tab[tri_slot(1, m)],
                            status: dim_dropped ? STAT_OVF : STAT_OK};
                end
                pending_answers.push_back(ans);
            end
        end else begin
            if (!chain_solved || fi == 0 || int'(li) > dims_count - 1 || fi > li) begin
                ans = '{cost: '0, split: '0, status: STAT_BAD};
            end else begin
                ans = '{cost: cost_tab[tri_slot(int'(fi), int'(li))],
                        split: split_tab[tri_slot(int'(fi), int'(li))],
                        status: STAT_OK};
            end
            pending_answers.push_back(ans);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: enters and leaves at a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(logic op, logic [DIM_W-1:0] dim, logic last,
                                logic [IDX_W-1:0] fi, logic [IDX_W-1:0] li);
        int gap;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_dim         <= dim;
        s_last        <= last;
        s_first_index <= fi;
        s_last_index  <= li;
        do @(posedge aclk); while (!s_ready);
        predict_chain_answer(op, dim, last, fi, li);
        items_sent++;
        @(negedge aclk);
    endtask

    // Index fields are don't-care on loads, dim and last on queries
    task automatic load_dim(logic [DIM_W-1:0] dim, logic last);
        send_request(OP_LOAD, dim, last, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic query_range(int fi, int li);
        send_request(OP_QUERY, DIM_W'($urandom), 1'($urandom), IDX_W'(fi), IDX_W'(li));
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result: cost %0d split %0d status %0d",
                       m_cost, m_split, m_status);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (m_cost !== want.cost) begin
                    $error("cost: expected %0d, actual %0d", want.cost, m_cost);
                    fail_count++;
                end
                if (m_split !== want.split) begin
                    $error("split: expected %0d, actual %0d", want.split, m_split);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    function automatic logic [DIM_W-1:0] pick_dim(int style, logic [DIM_W-1:0] base);
        case (style)
            0: return DIM_W'($urandom);
            1: return DIM_W'($urandom_range(1, 8));     // small values, many ties
            2: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return DIM_W'(1);
                    2: return '1;
                    default: return DIM_W'($urandom);
                endcase
            end
            default: return base;                       // flat chain
        endcase
    endfunction

    // A query before any chain, a chain of one dimension and a query after it
    task automatic test_not_ready_and_lone_dim();
        query_range(1, 1);
        load_dim(16'd7, 1'b1);
        query_range(1, 1);
    endtask

    // Four-dimension textbook chain, good and bad subchain queries
    task automatic test_textbook_chain();
        load_dim(16'd10, 1'b0);
        load_dim(16'd30, 1'b0);
        load_dim(16'd5, 1'b0);
        load_dim(16'd60, 1'b1);
        query_range(1, 3);
        query_range(1, 2);
        query_range(2, 3);
        query_range(1, 1);
        query_range(3, 3);
        query_range(0, 2);
        query_range(1, 4);
        query_range(3, 2);
        query_range(31, 31);
        query_range(16, 16);
    endtask

    // Single matrix of maximum dims, then an all-zero chain (ties everywhere)
    task automatic test_degenerate_chains();
        load_dim(16'hFFFF, 1'b0);
        load_dim(16'hFFFF, 1'b1);
        query_range(1, 1);
        load_dim(16'd0, 1'b0);
        load_dim(16'd0, 1'b0);
        load_dim(16'd0, 1'b1);
        query_range(1, 2);
        query_range(2, 2);
    endtask

    // Receiver holds off while requests keep coming; input must back up
    task automatic test_receiver_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        load_dim(16'd3, 1'b0);
        load_dim(16'd9, 1'b0);
        load_dim(16'd4, 1'b1);
        repeat (8) query_range($urandom_range(1, 2), 2);
    endtask

    // Mostly well-formed chains with follow-up queries, some broken requests
    task automatic test_random_chains(int n_items, int send_pct, int recv_pct);
        int               target;
        int               kind;
        int               sz;
        int               nd;
        int               style;
        int               m;
        int               fi;
        int               li;
        logic [DIM_W-1:0] base;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                sz = $urandom_range(99);
                if (sz < 80) nd = $urandom_range(2, 7);
                else if (sz < 93) nd = $urandom_range(8, 17);
                else nd = $urandom_range(18, 21);           // dims get dropped
                style = $urandom_range(3);
                base  = DIM_W'($urandom);
                for (int d = 0; d < nd; d++) load_dim(pick_dim(style, base), d == nd - 1);
                repeat ($urandom_range(6)) begin
                    if (chain_solved && $urandom_range(9) < 8) begin
                        m  = dims_count - 1;
                        fi = $urandom_range(1, m);
                        li = $urandom_range(fi, m);
                    end else begin
                        fi = $urandom_range(31);
                        li = $urandom_range(31);
                    end
                    query_range(fi, li);
                end
            end else if (kind < 85) begin
                // lone last load, then a query that is likely refused
                load_dim(DIM_W'($urandom), 1'b1);
                query_range($urandom_range(31), $urandom_range(31));
            end else begin
                send_request(1'($urandom), DIM_W'($urandom), 1'($urandom),
                             IDX_W'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_LOAD;
        s_dim          = '0;
        s_last         = 1'b0;
        s_first_index  = '0;
        s_last_index   = '0;
        dims_count     = 0;
        chain_solved   = 1'b0;
        dim_dropped    = 1'b0;
        fail_count     = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_not_ready_and_lone_dim();
        test_textbook_chain();
        test_degenerate_chains();
        test_receiver_hold();
        test_random_chains(500, 0, 0);
        test_random_chains(500, 60, 0);
        test_random_chains(500, 0, 60);
        test_random_chains(500, 6, 6);

        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
